// ----- design/rotate_point_about_center_assert.svh -----
// ----------------------------------------------------------------------------
// rotate_point_about_center assertion macros
// Shared property forms for the checks on the rotation block
// ----------------------------------------------------------------------------
`ifndef ROTATE_POINT_ABOUT_CENTER_ASSERT_SVH
`define ROTATE_POINT_ABOUT_CENTER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define RPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotate_point_about_center check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define RPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotate_point_about_center check failed");

`endif

// ----- design/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg
// Types, constants and the arctangent table for the point rotation block
// ----------------------------------------------------------------------------
package rpc_pkg;

    // angle units
    localparam int HALF_TURN_DEG       = 180;
    localparam int ANGLE_UNITS_PER_DEG = 64;
    localparam int FULL_TURN           = 2 * HALF_TURN_DEG * ANGLE_UNITS_PER_DEG;
    localparam int QUARTER_TURN        = FULL_TURN / 4;
    localparam int EIGHTH_TURN         = FULL_TURN / 8;

    // angle accumulator runs in 2^-24 degree
    localparam int Z_FRAC_BITS = 24;
    localparam int Z_SHIFT     = Z_FRAC_BITS - $clog2(ANGLE_UNITS_PER_DEG);
    localparam int Z_W         = 32;

    // datapath widths
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int GUARD_BITS = 8;
    localparam int VEC_W      = 44;
    localparam int SUM_W      = 37;
    localparam int ANGLE_W    = 16;
    localparam int RESID_W    = 16;
    localparam int UANGLE_W   = 15;

    // cordic gain in Q30 and the shift that leaves the guard bits
    localparam logic signed [31:0] GAIN_Q30   = 32'sd652032874;
    localparam int                 GAIN_SHIFT = 30 - GUARD_BITS;
    localparam int                 PROD_W     = DIFF_W + 32;

    // cordic depth and pipeline latency from accept to result strobe
    localparam int ROT_STAGES  = 18;
    localparam int RPC_LATENCY = ROT_STAGES + 4;

    // configuration port
    localparam int ADDR_W      = 3;
    localparam int REG_IDX_BIT = 2;
    localparam int DATA_W      = 32;
    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [ANGLE_W-1:0] angle_deg;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
        logic                      saturated;
    } out_t;

    // vector travelling through the cordic stages
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [Z_W-1:0]   z;
        logic                    rot;
    } vec_t;

    // atan(2^-i) in degrees, scaled by 2^24
    function automatic logic signed [Z_W-1:0] atan_q24(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 32'sd754974720;
            1:       v = 32'sd445687602;
            2:       v = 32'sd235489088;
            3:       v = 32'sd119537938;
            4:       v = 32'sd60000934;
            5:       v = 32'sd30029717;
            6:       v = 32'sd15018523;
            7:       v = 32'sd7509720;
            8:       v = 32'sd3754917;
            9:       v = 32'sd1877466;
            10:      v = 32'sd938734;
            11:      v = 32'sd469367;
            12:      v = 32'sd234684;
            13:      v = 32'sd117342;
            14:      v = 32'sd58671;
            15:      v = 32'sd29335;
            16:      v = 32'sd14668;
            17:      v = 32'sd7334;
            18:      v = 32'sd3667;
            19:      v = 32'sd1833;
            20:      v = 32'sd917;
            21:      v = 32'sd458;
            22:      v = 32'sd229;
            23:      v = 32'sd115;
            24:      v = 32'sd57;
            25:      v = 32'sd29;
            26:      v = 32'sd14;
            27:      v = 32'sd7;
            28:      v = 32'sd4;
            29:      v = 32'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/rotate_point_about_center.sv -----
// ----------------------------------------------------------------------------
// rotate_point_about_center
// Rotates a Q16.16 point about a programmable centre by a signed angle
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  point     start, busy, point_word                   in
//  result    done, result_word                         out
//  config    psel, penable, pwrite, paddr, pwdata,     in/out
//            prdata, pready
//
//  One word is taken every cycle; busy stays low.
//  Pipeline registers, in order: angle reduce, gain multiply, quarter turn,
//  one register per cordic stage, then round and saturate.
//  Reset clears the valid bits and both centre registers to zero.
//  The result sink cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module rotate_point_about_center (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rpc_pkg::in_t               point_word,
    output logic                       done,
    output rpc_pkg::out_t              result_word,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpc_pkg::ADDR_W-1:0] paddr,
    input  logic [rpc_pkg::DATA_W-1:0] pwdata,
    output logic [rpc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import rpc_pkg::*;

    // configuration registers
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic signed [COORD_W-1:0] cx_next, cy_next;
    logic                      cfg_wr;

    // stage 1: offset and angle split
    logic                      s1_valid_reg;
    logic signed [DIFF_W-1:0]  s1_dx_reg, s1_dy_reg;
    logic signed [Z_W-1:0]     s1_z_reg;
    logic                      s1_rot_reg;
    quad_t                     s1_quad_reg;

    logic signed [17:0]        a_ext;
    logic signed [17:0]        u_wide;
    logic [UANGLE_W-1:0]       u;
    logic [2:0]                qu;
    logic [RESID_W-1:0]        qoff;
    logic signed [RESID_W-1:0] resid;
    logic signed [DIFF_W-1:0]  dx_next, dy_next;
    logic signed [Z_W-1:0]     z_next;

    // stage 2: gain prescale
    logic                      s2_valid_reg;
    logic signed [VEC_W-1:0]   s2_x_reg, s2_y_reg;
    logic signed [Z_W-1:0]     s2_z_reg;
    logic                      s2_rot_reg;
    quad_t                     s2_quad_reg;
    logic signed [PROD_W-1:0]  prod_x, prod_y;
    logic signed [VEC_W-1:0]   x2_next, y2_next;

    // stage 3: quarter turn
    logic                      s3_valid_reg;
    vec_t                      s3_reg;
    vec_t                      s3_next;

    // cordic output
    logic                      c_valid;
    vec_t                      c_vec;

    // output stage
    logic                      done_reg;
    out_t                      result_reg;
    out_t                      result_next;
    logic signed [VEC_W-1:0]   xr, yr;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic                      clip_x, clip_y;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // config write and read
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (cfg_wr)
        begin
            case (paddr[REG_IDX_BIT])
                REG_CENTER_X: cx_next = $signed(pwdata);
                REG_CENTER_Y: cy_next = $signed(pwdata);
                default:      cx_next = cx_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    always_comb
    begin
        case (paddr[REG_IDX_BIT])
            REG_CENTER_X: prdata = cx_reg;
            REG_CENTER_Y: prdata = cy_reg;
            default:      prdata = '0;
        endcase
    end

    // angle modulo a full turn
    always_comb
    begin
        a_ext = 18'(point_word.angle_deg);
        if (a_ext >= 18'sd0 + 18'(FULL_TURN))
        begin
            u_wide = a_ext - 18'(FULL_TURN);
        end
        else if (a_ext >= 18'sd0)
        begin
            u_wide = a_ext;
        end
        else if (a_ext >= -18'(FULL_TURN))
        begin
            u_wide = a_ext + 18'(FULL_TURN);
        end
        else
        begin
            u_wide = a_ext + 18'(2 * FULL_TURN);
        end
        u = UANGLE_W'(u_wide);
    end

    // nearest quarter turn and residual
    always_comb
    begin
        if (u < UANGLE_W'(EIGHTH_TURN))
        begin
            qu = 3'd0;
        end
        else if (u < UANGLE_W'(EIGHTH_TURN + QUARTER_TURN))
        begin
            qu = 3'd1;
        end
        else if (u < UANGLE_W'(EIGHTH_TURN + 2 * QUARTER_TURN))
        begin
            qu = 3'd2;
        end
        else if (u < UANGLE_W'(EIGHTH_TURN + 3 * QUARTER_TURN))
        begin
            qu = 3'd3;
        end
        else
        begin
            qu = 3'd4;
        end

        case (qu)
            3'd0:    qoff = '0;
            3'd1:    qoff = RESID_W'(QUARTER_TURN);
            3'd2:    qoff = RESID_W'(2 * QUARTER_TURN);
            3'd3:    qoff = RESID_W'(3 * QUARTER_TURN);
            default: qoff = RESID_W'(FULL_TURN);
        endcase

        resid  = $signed({1'b0, u} - qoff);
        z_next = Z_W'(resid) <<< Z_SHIFT;
    end

    // offset from the centre, exact at 33 bits
    assign dx_next = DIFF_W'(point_word.point_x) - DIFF_W'(cx_reg);
    assign dy_next = DIFF_W'(point_word.point_y) - DIFF_W'(cy_reg);

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= dx_next;
        s1_dy_reg   <= dy_next;
        s1_z_reg    <= z_next;
        s1_rot_reg  <= (resid != '0);
        s1_quad_reg <= quad_t'(qu[1:0]);
    end

    // gain prescale, or plain guard shift for quarter turns
    always_comb
    begin
        prod_x = PROD_W'(s1_dx_reg) * PROD_W'(GAIN_Q30);
        prod_y = PROD_W'(s1_dy_reg) * PROD_W'(GAIN_Q30);
        if (s1_rot_reg)
        begin
            x2_next = VEC_W'(prod_x >>> GAIN_SHIFT);
            y2_next = VEC_W'(prod_y >>> GAIN_SHIFT);
        end
        else
        begin
            x2_next = VEC_W'(s1_dx_reg) <<< GUARD_BITS;
            y2_next = VEC_W'(s1_dy_reg) <<< GUARD_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_x_reg    <= x2_next;
        s2_y_reg    <= y2_next;
        s2_z_reg    <= s1_z_reg;
        s2_rot_reg  <= s1_rot_reg;
        s2_quad_reg <= s1_quad_reg;
    end

    // exact quarter-turn rotation
    always_comb
    begin
        s3_next.z   = s2_z_reg;
        s3_next.rot = s2_rot_reg;
        case (s2_quad_reg)
            QUAD_0:
            begin
                s3_next.x = s2_x_reg;
                s3_next.y = s2_y_reg;
            end
            QUAD_90:
            begin
                s3_next.x = -s2_y_reg;
                s3_next.y = s2_x_reg;
            end
            QUAD_180:
            begin
                s3_next.x = -s2_x_reg;
                s3_next.y = -s2_y_reg;
            end
            QUAD_270:
            begin
                s3_next.x = s2_y_reg;
                s3_next.y = -s2_x_reg;
            end
            default:
            begin
                s3_next.x = s2_x_reg;
                s3_next.y = s2_y_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s3_reg <= s3_next;
    end

    // front-end valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // residual rotation
    rpc_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .vec_in    (s3_reg),
        .out_valid (c_valid),
        .vec_out   (c_vec)
    );

    // round half up, add the centre back, saturate
    always_comb
    begin
        xr     = (c_vec.x + VEC_W'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
        yr     = (c_vec.y + VEC_W'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
        sum_x  = SUM_W'(xr) + SUM_W'(cx_reg);
        sum_y  = SUM_W'(yr) + SUM_W'(cy_reg);
        clip_x = 1'b0;
        clip_y = 1'b0;

        if (sum_x > $signed(SUM_W'({1'b0, {(COORD_W-1){1'b1}}})))
        begin
            result_next.rotated_x = {1'b0, {(COORD_W-1){1'b1}}};
            clip_x = 1'b1;
        end
        else if (sum_x < -$signed(SUM_W'({1'b1, {(COORD_W-1){1'b0}}})))
        begin
            result_next.rotated_x = {1'b1, {(COORD_W-1){1'b0}}};
            clip_x = 1'b1;
        end
        else
        begin
            result_next.rotated_x = COORD_W'(sum_x);
        end

        if (sum_y > $signed(SUM_W'({1'b0, {(COORD_W-1){1'b1}}})))
        begin
            result_next.rotated_y = {1'b0, {(COORD_W-1){1'b1}}};
            clip_y = 1'b1;
        end
        else if (sum_y < -$signed(SUM_W'({1'b1, {(COORD_W-1){1'b0}}})))
        begin
            result_next.rotated_y = {1'b1, {(COORD_W-1){1'b0}}};
            clip_y = 1'b1;
        end
        else
        begin
            result_next.rotated_y = COORD_W'(sum_y);
        end

        result_next.saturated = clip_x || clip_y;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_valid;
        end
    end

    assign done        = done_reg;
    assign result_word = result_reg;

endmodule

// ----- design/rpc_cordic.sv -----
// ----------------------------------------------------------------------------
// rpc_cordic
// Pipelined cordic rotator, one micro-rotation per register stage
// ----------------------------------------------------------------------------
module rpc_cordic (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  rpc_pkg::vec_t vec_in,
    output logic          out_valid,
    output rpc_pkg::vec_t vec_out
);
    import rpc_pkg::*;

    vec_t                  stage_reg [ROT_STAGES];
    logic [ROT_STAGES-1:0] valid_reg;
    logic [ROT_STAGES-1:0] valid_next;

    // valid bits travel alongside the stages
    assign valid_next = {valid_reg[ROT_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar i = 0; i < ROT_STAGES; i++)
    begin : g_stage
        vec_t cur;
        vec_t stage_next;

        if (i == 0)
        begin : g_first
            assign cur = vec_in;
        end
        else
        begin : g_rest
            assign cur = stage_reg[i-1];
        end

        // one micro-rotation, skipped for exact quarter turns
        always_comb
        begin
            stage_next = cur;
            if (cur.rot)
            begin
                if (!cur.z[Z_W-1])
                begin
                    stage_next.x = cur.x - (cur.y >>> i);
                    stage_next.y = cur.y + (cur.x >>> i);
                    stage_next.z = cur.z - atan_q24(i);
                end
                else
                begin
                    stage_next.x = cur.x + (cur.y >>> i);
                    stage_next.y = cur.y - (cur.x >>> i);
                    stage_next.z = cur.z + atan_q24(i);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[i] <= stage_next;
        end
    end

    assign out_valid = valid_reg[ROT_STAGES-1];
    assign vec_out   = stage_reg[ROT_STAGES-1];

endmodule

// ----- design/rpc_checker.sv -----
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks on the point rotation block, bound to the top level
// ----------------------------------------------------------------------------
`include "rotate_point_about_center_assert.svh"

module rpc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input rpc_pkg::in_t               point_word,
    input logic                       done,
    input rpc_pkg::out_t              result_word,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [rpc_pkg::ADDR_W-1:0] paddr,
    input logic [rpc_pkg::DATA_W-1:0] pwdata,
    input logic [rpc_pkg::DATA_W-1:0] prdata,
    input logic                       pready
);
    import rpc_pkg::*;

    localparam int AGE_W = $clog2(RPC_LATENCY + 1);

    logic [AGE_W-1:0] age_reg;
    logic [AGE_W-1:0] age_next;
    logic             x_inner, y_inner;
    logic             unused_in;

    // cycles since reset, held once the pipeline has filled
    assign age_next = (age_reg == AGE_W'(RPC_LATENCY)) ? age_reg : age_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= '0;
        end
        else
        begin
            age_reg <= age_next;
        end
    end

    // neither coordinate at a range limit
    assign x_inner = (result_word.rotated_x != {1'b0, {(COORD_W-1){1'b1}}}) &&
                     (result_word.rotated_x != {1'b1, {(COORD_W-1){1'b0}}});
    assign y_inner = (result_word.rotated_y != {1'b0, {(COORD_W-1){1'b1}}}) &&
                     (result_word.rotated_y != {1'b1, {(COORD_W-1){1'b0}}});
    assign unused_in = ^point_word;

    // one result per accepted word, once that word has passed the whole pipeline
    `RPC_ASSERT_IMP(a_done_latency, age_reg == AGE_W'(RPC_LATENCY), done == $past(start && !busy, RPC_LATENCY))

    // the flag only comes with a clipped coordinate
    `RPC_ASSERT_IMP(a_flag_needs_clip, done && x_inner && y_inner && !unused_in || done && x_inner && y_inner && unused_in, !result_word.saturated)

    // a written centre reads back on the next cycle
    `RPC_ASSERT_IMP(a_cfg_readback, age_reg != '0 && $past(rst_n) && $past(psel && penable && pwrite && pready) && paddr == $past(paddr), prdata == $past(pwdata))

    // the block never pushes back on either port
    `RPC_ASSERT_NXT(a_never_stalls, 1'b1, pready && !busy)

endmodule

bind rotate_point_about_center rpc_checker u_rpc_checker (.*);

// ----- sim/rotate_point_about_center_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_point_about_center_tb
// Streams points and angles into the rotation block under changing centres
// and checks every result word against an in-bench cordic predictor
// ----------------------------------------------------------------------------
module rotate_point_about_center_tb;

    import rpc_pkg::*;

    localparam int PHASE_WORDS = 280;
    localparam int NUM_PHASES  = 6;
    localparam int MAX_REPORTS = 10;
    localparam int TABLE_LEN   = 30;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

    // expected-result tracker: own centre copy and cordic predictor
    class rotation_checker;
        longint centre_x;
        longint centre_y;
        out_t   expected_rotations[$];
        int     fault_count;
        longint atan_deg[TABLE_LEN];

        function new();
            centre_x    = 0;
            centre_y    = 0;
            fault_count = 0;
            atan_deg = '{754974720, 445687602, 235489088, 119537938, 60000934,
                         30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                         469367, 234684, 117342, 58671, 29335, 14668, 7334,
                         3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};
        endfunction

        function void set_centre(logic idx, logic [DATA_W-1:0] v);
            if (idx == REG_CENTER_X)
                centre_x = longint'(signed'(v));
            else
                centre_y = longint'(signed'(v));
        endfunction

        // saturate to the signed 32-bit range, raising the flag on a clip
        function longint clip_coord(longint v, ref logic flag);
            if (v > longint'(COORD_MAX))
            begin
                flag = 1'b1;
                return longint'(COORD_MAX);
            end
            if (v < longint'(COORD_MIN))
            begin
                flag = 1'b1;
                return longint'(COORD_MIN);
            end
            return v;
        endfunction

        function out_t rotate_about_centre(in_t w);
            longint dx, dy, a, u, qu, resid, x, y, t, z, xs, ys, rx, ry;
            longint gain;
            quad_t  quad;
            logic   flag;
            int     n;
            out_t   res;
            flag  = 1'b0;
            gain  = longint'(GAIN_Q30);
            dx    = longint'(w.point_x) - centre_x;
            dy    = longint'(w.point_y) - centre_y;
            a     = longint'(w.angle_deg);
            // angle reduce to one turn, nearest quarter plus residual
            u = a % FULL_TURN;
            if (u < 0)
                u += FULL_TURN;
            qu    = (u + EIGHTH_TURN) / QUARTER_TURN;
            resid = u - qu * QUARTER_TURN;
            quad  = quad_t'(qu[1:0]);
            // gain prescale only when cordic stages run
            if (resid != 0)
            begin
                x = (dx * gain) >>> GAIN_SHIFT;
                y = (dy * gain) >>> GAIN_SHIFT;
            end
            else
            begin
                x = dx * (64'sd1 <<< GUARD_BITS);
                y = dy * (64'sd1 <<< GUARD_BITS);
            end
            // exact quarter turn
            case (quad)
                QUAD_90:
                begin
                    t = x;
                    x = -y;
                    y = t;
                end
                QUAD_180:
                begin
                    x = -x;
                    y = -y;
                end
                QUAD_270:
                begin
                    t = x;
                    x = y;
                    y = -t;
                end
                default:
                begin
                end
            endcase
            // cordic over the residual
            if (resid != 0)
            begin
                z = resid * (64'sd1 <<< Z_SHIFT);
                for (n = 0; n < ROT_STAGES && n < TABLE_LEN; n++)
                begin
                    xs = x >>> n;
                    ys = y >>> n;
                    if (z >= 0)
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - atan_deg[n];
                    end
                    else
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + atan_deg[n];
                    end
                end
            end
            // round half up, add centre back, saturate
            rx = ((x + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS) + centre_x;
            ry = ((y + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS) + centre_y;
            rx = clip_coord(rx, flag);
            ry = clip_coord(ry, flag);
            res.rotated_x = rx[COORD_W-1:0];
            res.rotated_y = ry[COORD_W-1:0];
            res.saturated = flag;
            return res;
        endfunction

        function void note_point(in_t w);
            expected_rotations.push_back(rotate_about_centre(w));
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_rotations.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result word: x=%0d y=%0d sat=%0b",
                             got.rotated_x, got.rotated_y, got.saturated);
                return;
            end
            want = expected_rotations.pop_front();
            if (got.rotated_x !== want.rotated_x || got.rotated_y !== want.rotated_y ||
                got.saturated !== want.saturated)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("mismatch: expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                             want.rotated_x, want.rotated_y, want.saturated,
                             got.rotated_x, got.rotated_y, got.saturated);
            end
        endfunction

        function int pending();
            return expected_rotations.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    in_t                 point_word;
    logic                done;
    out_t                result_word;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic signed [COORD_W-1:0] cur_cx;
    logic signed [COORD_W-1:0] cur_cy;

    rotation_checker tracker;

    rotate_point_about_center dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .point_word  (point_word),
        .done        (done),
        .result_word (result_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    always #5 clk = ~clk;

    // monitor: register writes, accepted words and result words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
                tracker.set_centre(paddr[REG_IDX_BIT], pwdata);
            if (start && !busy)
                tracker.note_point(point_word);
            if (done)
                tracker.check_result(result_word);
        end
    end

    function automatic in_t mk_point(logic [31:0] px, logic [31:0] py, int ang);
        in_t w;
        w.point_x   = px;
        w.point_y   = py;
        w.angle_deg = ang[ANGLE_W-1:0];
        return w;
    endfunction

    // random coordinate: mostly wide or near the centre, some extremes, some near zero
    function automatic logic [31:0] rand_coord(logic [31:0] ctr);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom;
        if (sel < 8)
            return ctr + 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        if (sel == 8)
        begin
            case ($urandom_range(0, 3))
                0:       return COORD_MAX;
                1:       return COORD_MIN;
                2:       return 32'd0;
                default: return 32'hffffffff;
            endcase
        end
        return 32'(int'($urandom_range(0, 255)) - 128);
    endfunction

    // random angle: full 16-bit, in range, quarter turns, their neighbours and the eighth turns between them
    function automatic int rand_angle();
        int sel;
        int k;
        sel = $urandom_range(0, 9);
        k   = int'($urandom_range(0, 7)) - 4;
        if (sel < 3)
            return int'($urandom_range(0, 65535));
        if (sel < 6)
            return int'($urandom_range(0, FULL_TURN - 1)) - FULL_TURN / 2 * 2 / 2
                   - (sel == 5 ? FULL_TURN / 2 : 0);
        if (sel < 8)
            return k * QUARTER_TURN;
        if (sel == 8)
            return k * QUARTER_TURN + (($urandom_range(0, 1) == 1) ? EIGHTH_TURN : -EIGHTH_TURN);
        return k * QUARTER_TURN + int'($urandom_range(0, 6)) - 3;
    endfunction

    // apb write: setup then access, entered and left on a falling edge
    task automatic write_reg(logic idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_centre(logic [31:0] cx, logic [31:0] cy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        cur_cx = cx;
        cur_cy = cy;
    endtask

    // hold start low until every outstanding result word is back
    task automatic drain();
        start = 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    // one point word with random idle gaps ahead of it
    task automatic send_point(in_t w, int idle_pct);
        while (int'($urandom_range(0, 99)) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        point_word = w;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // run limit
    initial
    begin
        #2ms;
        $display("[rotate_point_about_center] ERROR");
        $finish;
    end

    initial
    begin
        int ph;
        int i;
        int idle_pct;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        point_word = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cur_cx     = '0;
        cur_cy     = '0;
        tracker    = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: quarter turns, eighth turns, angle extremes, coordinate extremes
        send_point(mk_point(32'h00010000, 32'h0, 0), 14);
        send_point(mk_point(32'h00010000, 32'h0, QUARTER_TURN), 14);
        send_point(mk_point(32'h00010000, 32'h0, 2 * QUARTER_TURN), 14);
        send_point(mk_point(32'h00010000, 32'h0, 3 * QUARTER_TURN), 14);
        send_point(mk_point(32'h00010000, 32'h0, -QUARTER_TURN), 14);
        send_point(mk_point(32'h00010000, 32'h0, EIGHTH_TURN), 14);
        send_point(mk_point(32'h00010000, 32'h0, -EIGHTH_TURN), 14);
        send_point(mk_point(32'h00010000, 32'h00008000, 1), 14);
        send_point(mk_point(32'h00030000, 32'hfffe0000, FULL_TURN - 1), 14);
        send_point(mk_point(32'h00030000, 32'hfffe0000, -FULL_TURN), 14);
        send_point(mk_point(32'hfffe8000, 32'h00024000, 32767), 14);
        send_point(mk_point(32'hfffe8000, 32'h00024000, -32768), 14);
        send_point(mk_point(COORD_MAX, COORD_MAX, 0), 14);
        send_point(mk_point(COORD_MIN, COORD_MIN, 2 * QUARTER_TURN), 14);
        send_point(mk_point(COORD_MAX, COORD_MIN, QUARTER_TURN), 14);
        send_point(mk_point(COORD_MIN, COORD_MAX, EIGHTH_TURN), 14);
        send_point(mk_point(32'hffffffff, 32'hffffffff, 3 * QUARTER_TURN + 1), 14);
        send_point(mk_point(32'h0, 32'h0, 1234), 14);
        drain();

        // directed with an extreme centre
        set_centre(COORD_MAX, COORD_MIN);
        send_point(mk_point(COORD_MIN, COORD_MAX, 2 * QUARTER_TURN), 14);
        send_point(mk_point(COORD_MAX, COORD_MIN, EIGHTH_TURN), 14);
        send_point(mk_point(32'h0, 32'h0, QUARTER_TURN), 14);
        send_point(mk_point(COORD_MIN, COORD_MIN, -EIGHTH_TURN), 14);
        drain();

        // random phases, each under its own centre
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       set_centre($urandom, $urandom);
                1:       set_centre(COORD_MAX, COORD_MAX);
                2:       set_centre(COORD_MIN, COORD_MIN);
                3:       set_centre(32'h0, 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23)));
                4:       set_centre($urandom, COORD_MAX);
                default: set_centre(COORD_MIN, 32'h0);
            endcase
            idle_pct = (ph < 2) ? 14 : (ph < 4) ? 47 : 0;
            for (i = 0; i < PHASE_WORDS; i++)
            begin
                // occasional full pause until the pipeline empties
                if ($urandom_range(0, 199) == 0)
                    drain();
                send_point(mk_point(rand_coord(cur_cx), rand_coord(cur_cy), rand_angle()),
                           idle_pct);
            end
            drain();
        end

        // wind down
        start = 1'b0;
        drain();
        repeat (RPC_LATENCY + 10) @(negedge clk);
        tracker.fault_count += tracker.pending();
        if (tracker.fault_count == 0)
            $display("[rotate_point_about_center] OK");
        else
            $display("[rotate_point_about_center] ERROR");
        $finish;
    end

endmodule
